// ===== rtl/core/idc_pkg.sv =====
// shared types and constants for the convolution block
package idc_pkg;

	localparam int PIX_W  = 8;
	localparam int RES_W  = 21;
	localparam int COL_W  = 10;
	localparam int CFG_W  = 64;
	localparam int CIDX_W = 3;
	localparam int SUM_W  = 32;

	localparam logic [CIDX_W-1:0] REG_KSIZE = 3'd0;
	localparam logic [CIDX_W-1:0] REG_DIV   = 3'd1;
	localparam logic [CIDX_W-1:0] REG_MODE  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_BANK0 = 3'd3;
	localparam logic [CIDX_W-1:0] REG_BANK1 = 3'd4;
	localparam logic [CIDX_W-1:0] REG_BANK2 = 3'd5;
	localparam logic [CIDX_W-1:0] REG_BANK3 = 3'd6;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             row_end;
		logic             frame_start;
	} in_word_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result_value;
		logic [COL_W-1:0]        center_col;
		logic                    row_last;
	} out_word_t;

	// controller to datapath commands
	typedef struct packed {
		logic rd;      // read line store at current column
		logic upd;     // write line store and shift window
		logic mac;     // step the multiply-accumulate
		logic mac_clr; // start of accumulation
		logic div_go;  // start division
	} idc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic mac_last;
		logic div_done;
	} idc_sts_t;

endpackage

// ===== rtl/core/idc_ram.sv =====
// generic single port ram with registered read
module idc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		if (re) rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/core/idc_div.sv =====
// restoring divider, signed dividend by unsigned 16-bit divisor, truncating
module idc_div
	import idc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [15:0]             divisor,
	output logic                    done,
	output logic signed [SUM_W-1:0] quotient
);
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [15:0]      den_q;
	logic             neg_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic [SUM_W:0]   trial;
	logic [SUM_W-1:0] shifted;

	assign shifted = {rem_q[SUM_W-2:0], quo_q[SUM_W-1]};
	assign trial   = {1'b0, shifted} - {{(SUM_W-15){1'b0}}, den_q};

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath of the divider
	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
			rem_q <= '0;
			den_q <= (divisor == 16'd0) ? 16'd1 : divisor;
		end else if (busy_q) begin
			if (!trial[SUM_W]) begin
				rem_q <= trial[SUM_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

// ===== rtl/core/idc_datapath.sv =====
// line stores, window, multiply-accumulate and divide
module idc_datapath
	import idc_pkg::*;
#(
	parameter int MAX_KERNEL = 5,
	parameter int MAX_WIDTH  = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  idc_cmd_t                cmd,
	input  logic [PIX_W-1:0]        pix,
	input  logic [$clog2(MAX_WIDTH)-1:0] col,
	input  logic [2:0]              ksize,
	input  logic [15:0]             divisor,
	input  logic [8*25-1:0]         coefs,
	output idc_sts_t                sts,
	output logic signed [SUM_W-1:0] quotient
);
	localparam int NL = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;

	logic [PIX_W-1:0] line_rd [NL];
	logic [PIX_W-1:0] win_q [MAX_KERNEL][MAX_KERNEL];
	logic [2:0]       rr_q, qq_q;
	logic [4:0]       ti_q;
	logic signed [SUM_W-1:0] acc_q;
	logic signed [SUM_W-1:0] prod_s1;
	logic             prod_v_s1;
	logic [2:0]       off;
	logic [PIX_W-1:0] wsel;
	logic signed [7:0] csel;
	logic signed [PIX_W+8:0] prod_w;

	// line stores: each line written with the one below it at this column
	for (genvar l = 0; l < NL; l++) begin : g_line
		logic [PIX_W-1:0] wd;
		if (l == 0) begin : g_first
			assign wd = pix;
		end else begin : g_rest
			assign wd = line_rd[l-1];
		end
		idc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
			.clk  (clk),
			.we   (cmd.upd && (MAX_KERNEL > 1)),
			.re   (cmd.rd),
			.addr (col),
			.wdata(wd),
			.rdata(line_rd[l])
		);
	end

	// window shift: newest column enters at the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_KERNEL; r++)
				for (int q = 0; q < MAX_KERNEL; q++) win_q[r][q] <= '0;
		end else if (cmd.upd) begin
			for (int r = 0; r < MAX_KERNEL; r++) begin
				for (int q = 0; q < MAX_KERNEL - 1; q++) win_q[r][q] <= win_q[r][q+1];
				if (r == MAX_KERNEL - 1) win_q[r][MAX_KERNEL-1] <= pix;
				else win_q[r][MAX_KERNEL-1] <= line_rd[MAX_KERNEL-2-r];
			end
		end
	end

	assign off  = 3'(MAX_KERNEL) - ksize;
	assign wsel = win_q[off + rr_q][off + qq_q];
	assign csel = coefs[8*ti_q +: 8];

	// tap walk, one product per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q <= '0;
			qq_q <= '0;
			ti_q <= '0;
			prod_v_s1 <= 1'b0;
		end else begin
			prod_v_s1 <= cmd.mac;
			if (cmd.mac_clr) begin
				rr_q <= '0;
				qq_q <= '0;
				ti_q <= '0;
			end else if (cmd.mac) begin
				ti_q <= ti_q + 5'd1;
				if (qq_q == ksize - 3'd1) begin
					qq_q <= '0;
					rr_q <= rr_q + 3'd1;
				end else begin
					qq_q <= qq_q + 3'd1;
				end
			end
		end
	end

	// signed product of unsigned pixel and signed tap
	assign prod_w = $signed({1'b0, wsel}) * csel;

	// product register then accumulate
	always_ff @(posedge clk) begin
		prod_s1 <= SUM_W'(prod_w);
		if (cmd.mac_clr) acc_q <= '0;
		else if (prod_v_s1) acc_q <= acc_q + prod_s1;
	end

	assign sts.mac_last = (rr_q == ksize - 3'd1) && (qq_q == ksize - 3'd1);

	idc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (cmd.div_go),
		.dividend(acc_q),
		.divisor (divisor),
		.done    (sts.div_done),
		.quotient(quotient)
	);
endmodule

// ===== rtl/core/idc_ctrl.sv =====
// controller: position tracking, coverage and sequencing
module idc_ctrl
	import idc_pkg::*;
#(
	parameter int MAX_KERNEL = 5,
	parameter int MAX_WIDTH  = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_word_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_word_t              out_data,
	input  logic [2:0]             ksize,
	input  logic                   mode,
	input  idc_sts_t               sts,
	input  logic signed [SUM_W-1:0] quotient,
	output idc_cmd_t               cmd,
	output logic [PIX_W-1:0]       pix,
	output logic [$clog2(MAX_WIDTH)-1:0] col
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int NW = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_MAC  = 3'd3;
	localparam logic [2:0] ST_DRN  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;

	logic [2:0]       state_q;
	logic [CW-1:0]    colcnt_q;
	logic [CW-1:0]    c_q;
	logic [2:0]       rows_q;
	logic [CW-1:0]    width_q [NW];
	logic [PIX_W-1:0] pix_q;
	logic             re_q, ok_q, store_q;
	logic [1:0]       drain_q;
	logic [2:0]       keff;
	logic             in_acc;
	logic [CW-1:0]    c_now;
	logic [2:0]       rows_now;
	logic             ok_now;
	logic [CW-1:0]    cc_after;
	logic signed [SUM_W-1:0] clamped;

	assign keff   = (ksize == 3'd0) ? 3'd1 :
		(ksize > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : ksize;
	assign in_stall = (state_q != ST_IDLE) || (out_valid && out_stall);
	assign in_acc   = in_valid && !in_stall;

	assign c_now    = in_data.frame_start ? '0 : colcnt_q;
	assign rows_now = in_data.frame_start ? '0 : rows_q;

	// coverage test of the window ending at this pixel
	always_comb begin
		ok_now = (c_now < CW'(MAX_WIDTH)) && ({1'b0, c_now} + (CW+1)'(1) >= (CW+1)'(keff))
			&& ({1'b0, rows_now} + 4'd1 >= {1'b0, keff});
		for (int j = 1; j < MAX_KERNEL; j++)
			if (j < keff && !in_data.frame_start && c_now >= width_q[j-1]) ok_now = 1'b0;
		if (in_data.frame_start && keff > 3'd1) ok_now = 1'b0;
	end

	assign cc_after = (c_now < CW'(MAX_WIDTH)) ? c_now + 1'b1 : c_now;

	// position bookkeeping at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colcnt_q <= '0;
			rows_q   <= '0;
			for (int j = 0; j < NW; j++) width_q[j] <= '0;
		end else if (in_acc) begin
			if (in_data.row_end) begin
				for (int j = NW - 1; j >= 1; j--)
					width_q[j] <= in_data.frame_start ? '0 : width_q[j-1];
				width_q[0] <= cc_after;
				if (rows_now < 3'(MAX_KERNEL - 1)) rows_q <= rows_now + 3'd1;
				else rows_q <= rows_now;
				colcnt_q <= '0;
			end else begin
				if (in_data.frame_start) begin
					for (int j = 0; j < NW; j++) width_q[j] <= '0;
				end
				rows_q   <= rows_now;
				colcnt_q <= cc_after;
			end
		end
	end

	// item registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q   <= in_data.pixel;
			re_q    <= in_data.row_end;
			c_q     <= c_now;
			ok_q    <= ok_now;
			store_q <= c_now < CW'(MAX_WIDTH);
		end
	end

	assign pix = pix_q;
	assign col = c_q[AW-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			drain_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_READ;
				ST_READ: state_q <= store_q ? ST_UPD : ST_IDLE;
				ST_UPD:  state_q <= ok_q ? ST_MAC : ST_IDLE;
				ST_MAC: begin
					if (sts.mac_last) begin
						state_q <= ST_DRN;
						drain_q <= 2'd2;
					end
				end
				ST_DRN: begin
					drain_q <= drain_q - 2'd1;
					if (drain_q == 2'd1) state_q <= ST_DIV;
				end
				ST_DIV: if (sts.div_done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// commands
	always_comb begin
		cmd         = '0;
		cmd.rd      = (state_q == ST_READ) && store_q;
		cmd.upd     = state_q == ST_UPD;
		cmd.mac_clr = state_q == ST_UPD;
		cmd.mac     = state_q == ST_MAC;
		cmd.div_go  = (state_q == ST_DRN) && (drain_q == 2'd1);
	end

	assign clamped = (quotient > 255) ? 32'sd255 : (quotient < 0) ? '0 : quotient;

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (state_q == ST_DIV && sts.div_done) out_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && sts.div_done) begin
			out_data.result_value <= mode ? quotient[RES_W-1:0] : clamped[RES_W-1:0];
			out_data.center_col   <= COL_W'(c_q - CW'(keff - 3'd1) + CW'(keff >> 1));
			out_data.row_last     <= re_q;
		end
	end

	ast_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
	ast_out_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DIV) else $error("word not from divide");
	ast_mac_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && ok_q) |=> state_q == ST_MAC) else $error("mac skipped");
endmodule

// ===== rtl/core/image_convolution_divide_clamp_top.sv =====
// top level: configuration registers, controller and datapath
// a pixel word with no result passes the read and update states (past the line width
// only the read state); a result word then takes the tap walk, a drain and the divide
// (one tap product per cycle, then a 32-step serial divide) before it is registered;
// throughput is one word at a time, set by the tap walk and the divider
// asynchronous active-low reset clears control state and loads the 3x3 identity kernel
module image_convolution_divide_clamp_top
	import idc_pkg::*;
#(
	parameter int MAX_KERNEL = 5,
	parameter int MAX_WIDTH  = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_word_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_word_t         out_data,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);
	logic [2:0]   ksize_q;
	logic [15:0]  div_q;
	logic         mode_q;
	logic [199:0] coef_q;
	idc_cmd_t     cmd;
	idc_sts_t     sts;
	logic signed [SUM_W-1:0] quotient;
	logic [PIX_W-1:0] pix;
	logic [$clog2(MAX_WIDTH)-1:0] col;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksize_q <= 3'd3;
			div_q   <= 16'd1;
			mode_q  <= 1'b0;
			coef_q  <= {136'd0, 64'h0000_0001_0000_0000};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KSIZE: ksize_q <= cfg_data[2:0];
				REG_DIV:   div_q   <= cfg_data[15:0];
				REG_MODE:  mode_q  <= cfg_data[0];
				REG_BANK0: coef_q[63:0]    <= cfg_data;
				REG_BANK1: coef_q[127:64]  <= cfg_data;
				REG_BANK2: coef_q[191:128] <= cfg_data;
				REG_BANK3: coef_q[199:192] <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	idc_ctrl #(.MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.ksize(ksize_q), .mode(mode_q), .sts(sts), .quotient(quotient),
		.cmd(cmd), .pix(pix), .col(col)
	);

	idc_datapath #(.MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .pix(pix), .col(col),
		.ksize((ksize_q == 3'd0) ? 3'd1 : (ksize_q > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : ksize_q),
		.divisor(div_q), .coefs(coef_q), .sts(sts), .quotient(quotient)
	);
endmodule
